[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/dbgp_pkg.sv]
package dbgp_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FOCAL       = 3'd0;
  localparam logic [2:0] REG_CENTER_COL  = 3'd1;
  localparam logic [2:0] REG_CENTER_ROW  = 3'd2;
  localparam logic [2:0] REG_BASELINE    = 3'd3;
  localparam logic [2:0] REG_HALF_WIDTH  = 3'd4;
  localparam logic [2:0] REG_MAX_DEPTH   = 3'd5;
  localparam logic [2:0] REG_HALF_HEIGHT = 3'd6;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd7;

  // Reset values of the registers.
  localparam logic [15:0] FOCAL_RST       = 16'd0;
  localparam logic [15:0] CENTER_COL_RST  = 16'd0;
  localparam logic [15:0] CENTER_ROW_RST  = 16'd0;
  localparam logic [11:0] BASELINE_RST    = 12'd1;
  localparam logic [15:0] HALF_WIDTH_RST  = 16'd10000;
  localparam logic [15:0] MAX_DEPTH_RST   = 16'd30000;
  localparam logic [15:0] HALF_HEIGHT_RST = 16'd1000;
  localparam logic [15:0] CELL_SIZE_RST   = 16'd100;

  // Base value a cell holds before the height is taken off.
  localparam logic signed [29:0] CELL_BASE_MM = 30'sd4000;

  // Numerator and quotient width, and divisor width, of the reprojection divide.
  localparam int NUM_W  = 28;
  localparam int DISP_W = 15;
  // Numerator and divisor widths of the grid divide.
  localparam int GRID_W = 17;
  localparam int CELL_W = 16;

  // Saturation limits of the position fields.
  localparam logic signed [29:0] POS_MAX = 30'sd8388607;
  localparam logic signed [29:0] POS_MIN = -30'sd8388608;
  localparam logic [NUM_W-1:0]   DEPTH_MAX = 28'd8388607;

  typedef struct packed {
    logic [15:0] focal_length;
    logic [15:0] center_col;
    logic [15:0] center_row;
    logic [11:0] baseline_mm;
    logic [15:0] half_width_mm;
    logic [15:0] max_depth_mm;
    logic [15:0] half_height_mm;
    logic [15:0] cell_size_mm;
  } cfg_t;

  // Item handed from the front to the back: numerator magnitudes and signs.
  typedef struct packed {
    logic              sign_x;
    logic              sign_y;
    logic [NUM_W-1:0]  mag_x;
    logic [NUM_W-1:0]  mag_y;
    logic [NUM_W-1:0]  mag_z;
    logic [DISP_W-1:0] disp;
  } mid_t;

  // Fields settled before the grid divide.
  typedef struct packed {
    logic signed [23:0] pos_x_mm;
    logic signed [23:0] pos_y_mm;
    logic [22:0]        pos_z_mm;
    logic               in_grid;
    logic signed [17:0] cell_value;
  } part_t;

  typedef struct packed {
    part_t       part;
    logic [15:0] grid_depth_index;
    logic [16:0] grid_lateral_index;
  } res_t;

endpackage

[hdl/dbgp_fifo.sv]
module dbgp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rdata = mem[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push && !pop, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)
  `ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty)
endmodule

[hdl/dbgp_div.sv]
module dbgp_div #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [SW-1:0]              side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [LANES-1:0]           rem_nz,
  output logic [SW-1:0]              side_out
);
  // One quotient bit per stage. The shift register holds the dividend bits
  // still to be consumed at the top and the quotient bits built so far below.
  logic [LANES-1:0][NW-1:0] sh_q   [NW];
  logic [LANES-1:0][DW-1:0] rem_q  [NW];
  logic [DW-1:0]            den_q  [NW];
  logic [SW-1:0]            side_q [NW];
  logic [NW-1:0]            v_q;

  logic [LANES-1:0][NW-1:0] sh_p   [NW];
  logic [LANES-1:0][DW-1:0] rem_p  [NW];
  logic [DW-1:0]            den_p  [NW];
  logic [SW-1:0]            side_p [NW];
  logic [NW-1:0]            v_p;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    // Stage inputs come from the ports or from the stage before.
    if (k == 0) begin : g_first
      assign sh_p[k]   = num;
      assign rem_p[k]  = '0;
      assign den_p[k]  = den;
      assign side_p[k] = side;
      assign v_p[k]    = in_valid;
    end else begin : g_next
      assign sh_p[k]   = sh_q[k-1];
      assign rem_p[k]  = rem_q[k-1];
      assign den_p[k]  = den_q[k-1];
      assign side_p[k] = side_q[k-1];
      assign v_p[k]    = v_q[k-1];
    end

    // Trial subtraction for each lane.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW+1:0] diff;
      logic          ge;
      assign diff = {1'b0, rem_p[k][l], sh_p[k][l][NW-1]} - {2'b00, den_p[k]};
      assign ge   = !diff[DW+1];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][l] <= ge ? diff[DW-1:0] : {rem_p[k][l][DW-2:0], sh_p[k][l][NW-1]};
          sh_q[k][l]  <= {sh_p[k][l][NW-2:0], ge};
        end
      end
    end

    // Divisor and sideband ride along with the item.
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k]  <= den_p[k];
        side_q[k] <= side_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_p[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign rem_nz[l] = |rem_q[NW-1][l];
  end

  assign out_valid = v_q[NW-1];
  assign quo       = sh_q[NW-1];
  assign side_out  = side_q[NW-1];
endmodule

[hdl/dbgp_front.sv]
module dbgp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  dbgp_pkg::cfg_t       cfg,
  input  logic                 push,
  output logic                 full,
  input  logic [10:0]          pixel_row,
  input  logic [10:0]          pixel_col,
  input  logic signed [15:0]   disparity_q4,
  input  logic                 obstacle_mark,
  input  logic                 mid_full,
  output logic                 mid_push,
  output dbgp_pkg::mid_t       mid_data
);
  import dbgp_pkg::*;

  logic              f_valid;
  logic [10:0]       f_row;
  logic [10:0]       f_col;
  logic [DISP_W-1:0] f_disp;
  logic              keep;
  logic              advance;

  logic signed [18:0] num_x;
  logic signed [18:0] num_y;
  logic [16:0]        abs_x;
  logic [16:0]        abs_y;
  logic [28:0]        prod_x;
  logic [28:0]        prod_y;

  // Only marked pixels with a positive disparity go on.
  assign keep    = obstacle_mark && !disparity_q4[15] && (disparity_q4 != 16'sd0);
  assign advance = !f_valid || !mid_full;
  assign full    = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= push && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_row  <= pixel_row;
      f_col  <= pixel_col;
      f_disp <= disparity_q4[DISP_W-1:0];
    end
  end

  // Offsets from the principal point, in sixteenths of a pixel.
  assign num_x = $signed({4'b0, f_col, 4'b0}) + 19'sd16 - $signed({3'b0, cfg.center_col});
  assign num_y = $signed({4'b0, f_row, 4'b0}) + 19'sd16 - $signed({3'b0, cfg.center_row});
  assign abs_x = num_x[18] ? 17'(-num_x) : num_x[16:0];
  assign abs_y = num_y[18] ? 17'(-num_y) : num_y[16:0];

  // Scale by the baseline; the queue register follows the multipliers.
  assign prod_x = abs_x * cfg.baseline_mm;
  assign prod_y = abs_y * cfg.baseline_mm;

  always_comb begin
    mid_data.sign_x = num_x[18];
    mid_data.sign_y = num_y[18];
    mid_data.mag_x  = prod_x[NUM_W-1:0];
    mid_data.mag_y  = prod_y[NUM_W-1:0];
    mid_data.mag_z  = cfg.focal_length * cfg.baseline_mm;
    mid_data.disp   = f_disp;
  end

  assign mid_push = f_valid && !mid_full;
endmodule

[hdl/dbgp_back.sv]
module dbgp_back (
  input  logic           clk,
  input  logic           rst,
  input  dbgp_pkg::cfg_t cfg,
  input  logic           mid_empty,
  input  dbgp_pkg::mid_t mid_data,
  output logic           mid_pop,
  input  logic           out_full,
  output logic           out_push,
  output dbgp_pkg::res_t out_data
);
  import dbgp_pkg::*;

  logic adv;

  logic                          a_valid;
  logic [2:0][NUM_W-1:0]         a_quo;
  logic [2:0]                    a_rnz;
  logic [1:0]                    a_sign;

  logic signed [29:0] mag_x;
  logic signed [29:0] mag_y;
  logic signed [29:0] x;
  logic signed [29:0] y;
  logic [NUM_W-1:0]   z;
  logic signed [29:0] hw;
  logic signed [29:0] hh;
  logic signed [29:0] lat;
  logic signed [29:0] cv;
  logic               in_box;
  part_t              part_next;

  logic                    b_valid;
  part_t                   b_part;
  logic [1:0][GRID_W-1:0]  b_num;
  logic [CELL_W-1:0]       b_cell;

  logic                    c_valid;
  logic [1:0][GRID_W-1:0]  c_quo;
  part_t                   c_part;

  // The whole back pipeline moves whenever the result queue has room.
  assign adv     = !out_full;
  assign mid_pop = adv && !mid_empty;

  // Reprojection divide: lateral, vertical and depth share the disparity.
  dbgp_div #(.LANES(3), .NW(NUM_W), .DW(DISP_W), .SW(2)) u_div_pos (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (mid_pop),
    .num      ({mid_data.mag_z, mid_data.mag_y, mid_data.mag_x}),
    .den      (mid_data.disp),
    .side     ({mid_data.sign_y, mid_data.sign_x}),
    .out_valid(a_valid),
    .quo      (a_quo),
    .rem_nz   (a_rnz),
    .side_out (a_sign)
  );

  // Floor toward minus infinity for negative numerators.
  assign mag_x = $signed({2'b0, a_quo[0]}) + $signed({29'b0, a_rnz[0]});
  assign mag_y = $signed({2'b0, a_quo[1]}) + $signed({29'b0, a_rnz[1]});
  assign x     = a_sign[0] ? -mag_x : $signed({2'b0, a_quo[0]});
  assign y     = a_sign[1] ? -mag_y : $signed({2'b0, a_quo[1]});
  assign z     = a_quo[2];

  // Box test on the unsaturated coordinates.
  assign hw     = $signed({14'b0, cfg.half_width_mm});
  assign hh     = $signed({14'b0, cfg.half_height_mm});
  assign in_box = (x >= -hw) && (x <= hw) && (y >= -hh) && (y <= hh)
               && (z <= {12'b0, cfg.max_depth_mm});
  assign lat    = x + hw;
  assign cv     = CELL_BASE_MM - y;

  // Saturate positions and settle the cell value.
  always_comb begin
    if (x > POS_MAX) begin
      part_next.pos_x_mm = 24'sh7FFFFF;
    end else if (x < POS_MIN) begin
      part_next.pos_x_mm = 24'sh800000;
    end else begin
      part_next.pos_x_mm = x[23:0];
    end
    if (y > POS_MAX) begin
      part_next.pos_y_mm = 24'sh7FFFFF;
    end else if (y < POS_MIN) begin
      part_next.pos_y_mm = 24'sh800000;
    end else begin
      part_next.pos_y_mm = y[23:0];
    end
    part_next.pos_z_mm   = (z > DEPTH_MAX) ? 23'h7FFFFF : z[22:0];
    part_next.in_grid    = in_box;
    part_next.cell_value = in_box ? cv[17:0] : 18'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  // Grid numerators are zero outside the box, so the indices come out zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_part   <= part_next;
      b_num[0] <= in_box ? z[GRID_W-1:0] : '0;
      b_num[1] <= in_box ? lat[GRID_W-1:0] : '0;
      b_cell   <= (cfg.cell_size_mm == '0) ? CELL_W'(1) : cfg.cell_size_mm;
    end
  end

  // Grid divide by the cell size.
  dbgp_div #(.LANES(2), .NW(GRID_W), .DW(CELL_W), .SW($bits(part_t))) u_div_grid (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_valid),
    .num      (b_num),
    .den      (b_cell),
    .side     (b_part),
    .out_valid(c_valid),
    .quo      (c_quo),
    .rem_nz   (),
    .side_out (c_part)
  );

  assign out_push                    = adv && c_valid;
  assign out_data.part               = c_part;
  assign out_data.grid_depth_index   = c_quo[0][15:0];
  assign out_data.grid_lateral_index = c_quo[1];
endmodule

[hdl/disparity_to_bev_grid_point_unit.sv]
// Channel   Direction  Handshake             Payload
// pixel     in         push / full           pixel_row, pixel_col, disparity_q4, obstacle_mark
// point     out        pop / empty           pos_x/y/z_mm, in_grid, grid indices, cell_value
// config    in         psel/penable/pready   paddr, pwdata, prdata (8 registers at 4*i)
//
// One item is taken per cycle while full is low. From accept to result an item
// passes one front stage, the middle queue, 28 stages of the reprojection
// divider, one box-test stage and 17 stages of the grid divider.
// Reset is synchronous and clears the registers to their defaults and all queues.
// A full result queue stalls the back pipeline; the middle queue then absorbs
// the front until it fills and raises full. Unmarked or non-positive pixels
// are dropped in the front and give no item.
module disparity_to_bev_grid_point_unit #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [10:0]        pixel_row,
  input  logic [10:0]        pixel_col,
  input  logic signed [15:0] disparity_q4,
  input  logic               obstacle_mark,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] pos_x_mm,
  output logic signed [23:0] pos_y_mm,
  output logic [22:0]        pos_z_mm,
  output logic               in_grid,
  output logic [15:0]        grid_depth_index,
  output logic [16:0]        grid_lateral_index,
  output logic signed [17:0] cell_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dbgp_pkg::*;

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       wr_en;

  logic mid_push;
  logic mid_pop;
  logic mid_full;
  logic mid_empty;
  mid_t mid_wdata;
  mid_t mid_rdata;

  logic out_push;
  logic out_full;
  res_t out_wdata;
  res_t out_rdata;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_length   <= FOCAL_RST;
      cfg.center_col     <= CENTER_COL_RST;
      cfg.center_row     <= CENTER_ROW_RST;
      cfg.baseline_mm    <= BASELINE_RST;
      cfg.half_width_mm  <= HALF_WIDTH_RST;
      cfg.max_depth_mm   <= MAX_DEPTH_RST;
      cfg.half_height_mm <= HALF_HEIGHT_RST;
      cfg.cell_size_mm   <= CELL_SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FOCAL:       cfg.focal_length   <= pwdata[15:0];
        REG_CENTER_COL:  cfg.center_col     <= pwdata[15:0];
        REG_CENTER_ROW:  cfg.center_row     <= pwdata[15:0];
        REG_BASELINE:    cfg.baseline_mm    <= pwdata[11:0];
        REG_HALF_WIDTH:  cfg.half_width_mm  <= pwdata[15:0];
        REG_MAX_DEPTH:   cfg.max_depth_mm   <= pwdata[15:0];
        REG_HALF_HEIGHT: cfg.half_height_mm <= pwdata[15:0];
        REG_CELL_SIZE:   cfg.cell_size_mm   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_FOCAL:       prdata = {16'b0, cfg.focal_length};
      REG_CENTER_COL:  prdata = {16'b0, cfg.center_col};
      REG_CENTER_ROW:  prdata = {16'b0, cfg.center_row};
      REG_BASELINE:    prdata = {20'b0, cfg.baseline_mm};
      REG_HALF_WIDTH:  prdata = {16'b0, cfg.half_width_mm};
      REG_MAX_DEPTH:   prdata = {16'b0, cfg.max_depth_mm};
      REG_HALF_HEIGHT: prdata = {16'b0, cfg.half_height_mm};
      REG_CELL_SIZE:   prdata = {16'b0, cfg.cell_size_mm};
      default:         prdata = '0;
    endcase
  end

  // Front: accepts and screens pixels, forms scaled numerators.
  dbgp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .disparity_q4 (disparity_q4),
    .obstacle_mark(obstacle_mark),
    .mid_full     (mid_full),
    .mid_push     (mid_push),
    .mid_data     (mid_wdata)
  );

  // Queue between front and back.
  dbgp_fifo #(.W($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .wdata(mid_wdata),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty)
  );

  // Back: divides, box test and grid placement.
  dbgp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_empty(mid_empty),
    .mid_data (mid_rdata),
    .mid_pop  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_wdata)
  );

  // Result queue.
  dbgp_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_wdata),
    .pop  (pop && !empty),
    .rdata(out_rdata),
    .full (out_full),
    .empty(empty)
  );

  assign pos_x_mm           = out_rdata.part.pos_x_mm;
  assign pos_y_mm           = out_rdata.part.pos_y_mm;
  assign pos_z_mm           = out_rdata.part.pos_z_mm;
  assign in_grid            = out_rdata.part.in_grid;
  assign cell_value         = out_rdata.part.cell_value;
  assign grid_depth_index   = out_rdata.grid_depth_index;
  assign grid_lateral_index = out_rdata.grid_lateral_index;
endmodule
